@@ rtl/core/b32wc_pkg.sv @@
`timescale 1ns / 1ps
package b32wc_pkg;

	localparam int WORD_W          = 64;
	localparam int WORD_BYTES      = 8;
	localparam int WORD_DIGITS     = 13;
	localparam int CNT_W           = 4;
	localparam int QUEUE_DEPTH_DEF = 2;

	typedef enum logic {
		MODE_ENC = 1'b0,
		MODE_DEC = 1'b1
	} mode_t;

	// one finished group handed from front to back
	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic [CNT_W-1:0]  cnt;
		mode_t             mode;
	} job_t;

	function automatic logic [7:0] digit_char(input logic [4:0] d);
		logic [7:0] c;
		c = 8'h40;
		unique case (d)
			5'd0:  c = 8'h40;
			5'd27: c = 8'h33;
			5'd28: c = 8'h34;
			5'd29: c = 8'h35;
			5'd30: c = 8'h36;
			5'd31: c = 8'h37;
			default: c = 8'h60 + {3'b000, d};
		endcase
		return c;
	endfunction

	// characters sent for a word of n bytes: ceil(n*8/5)
	function automatic logic [CNT_W-1:0] enc_results(input logic [CNT_W-1:0] n);
		logic [CNT_W-1:0] r;
		r = '0;
		unique case (n)
			4'd1: r = 4'd2;
			4'd2: r = 4'd4;
			4'd3: r = 4'd5;
			4'd4: r = 4'd7;
			4'd5: r = 4'd8;
			4'd6: r = 4'd10;
			4'd7: r = 4'd12;
			4'd8: r = 4'd13;
			default: r = '0;
		endcase
		return r;
	endfunction

	// bytes given by n characters: floor(n*5/8)
	function automatic logic [CNT_W-1:0] dec_results(input logic [CNT_W-1:0] n);
		logic [CNT_W-1:0] r;
		r = '0;
		unique case (n)
			4'd2, 4'd3:   r = 4'd1;
			4'd4:         r = 4'd2;
			4'd5, 4'd6:   r = 4'd3;
			4'd7:         r = 4'd4;
			4'd8, 4'd9:   r = 4'd5;
			4'd10, 4'd11: r = 4'd6;
			4'd12:        r = 4'd7;
			4'd13:        r = 4'd8;
			default:      r = '0;
		endcase
		return r;
	endfunction

endpackage

@@ rtl/core/b32_item_if.sv @@
`timescale 1ns / 1ps
interface b32_item_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_in;
	logic       last_in;

	modport source (output valid, output data_in, output last_in, input ready);
	modport sink (input valid, input data_in, input last_in, output ready);
endinterface

@@ rtl/core/b32_result_if.sv @@
`timescale 1ns / 1ps
interface b32_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_out;
	logic       last_out;

	modport source (output valid, output data_out, output last_out, input ready);
	modport sink (input valid, input data_out, input last_out, output ready);
endinterface

@@ rtl/core/b32_cfg_if.sv @@
`timescale 1ns / 1ps
interface b32_cfg_if;
	logic valid;
	logic ready;
	logic data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/b32wc_front.sv @@
`timescale 1ns / 1ps
module b32wc_front (
	input  logic            clk,
	input  logic            arst_n,
	b32_item_if.sink        item,
	input  b32wc_pkg::mode_t mode,
	input  logic            clr,
	input  logic            q_full,
	output logic            push,
	output b32wc_pkg::job_t job
);
	import b32wc_pkg::*;

	logic [WORD_W-1:0] acc_q;
	logic [CNT_W-1:0]  cnt_q;

	logic              accept;
	logic              is_dec;
	logic [4:0]        digit;
	logic [2:0]        enc_pos;
	logic [CNT_W-1:0]  dec_pos;
	logic [5:0]        sh_enc;
	logic [5:0]        sh_dec;
	logic [WORD_W-1:0] ins;
	logic [WORD_W-1:0] acc_nx;
	logic [CNT_W-1:0]  n_nx;
	logic              grp_full;
	logic              done;
	logic [CNT_W-1:0]  res;

	assign item.ready = !q_full;
	assign accept     = item.valid && item.ready;
	assign is_dec     = (mode == MODE_DEC);

	always_comb begin
		digit   = item.data_in[4:0] ^ {1'b0, ~item.data_in[6], 3'b000};
		enc_pos = cnt_q[2:0];
		dec_pos = (cnt_q >= CNT_W'(WORD_DIGITS)) ? '0 : cnt_q;
		sh_enc  = {enc_pos, 3'b000};
		sh_dec  = {dec_pos, 2'b00} + {2'b00, dec_pos};
		if (is_dec) begin
			ins  = {{(WORD_W-5){1'b0}}, digit} << sh_dec;
			n_nx = dec_pos + 1'b1;
			grp_full = (n_nx == CNT_W'(WORD_DIGITS));
			res  = dec_results(n_nx);
		end else begin
			ins  = {{(WORD_W-8){1'b0}}, item.data_in} << sh_enc;
			n_nx = {1'b0, enc_pos} + 1'b1;
			grp_full = (n_nx == CNT_W'(WORD_BYTES));
			res  = enc_results(n_nx);
		end
		acc_nx = acc_q | ins;
		done   = grp_full || item.last_in;
		push   = accept && done && (res != '0);
		job    = '{word: acc_nx, cnt: res, mode: mode};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			cnt_q <= '0;
		end else if (clr) begin
			acc_q <= '0;
			cnt_q <= '0;
		end else if (accept) begin
			if (done) begin
				acc_q <= '0;
				cnt_q <= '0;
			end else begin
				acc_q <= acc_nx;
				cnt_q <= n_nx;
			end
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q < CNT_W'(WORD_DIGITS))
		else $error("group count out of range");
	a_enc_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		!is_dec |-> cnt_q < CNT_W'(WORD_BYTES))
		else $error("encode group count past a word");
	a_push_space: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full && job.cnt != '0)
		else $error("job pushed into full queue or empty job");
endmodule

@@ rtl/core/b32wc_queue.sv @@
`timescale 1ns / 1ps
module b32wc_queue #(
	parameter int DEPTH = b32wc_pkg::QUEUE_DEPTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  b32wc_pkg::job_t wr_job,
	output logic            full,
	output logic            valid,
	input  logic            pop,
	output b32wc_pkg::job_t head
);
	import b32wc_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	job_t           mem [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  cnt_q;

	assign full  = (cnt_q == CW'(DEPTH));
	assign valid = (cnt_q != '0);
	assign head  = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem[wr_ptr_q] <= wr_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> valid)
		else $error("queue underflow");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("queue count past depth");
endmodule

@@ rtl/core/b32wc_back.sv @@
`timescale 1ns / 1ps
module b32wc_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	input  b32wc_pkg::job_t q_head,
	output logic            pop,
	b32_result_if.source    result
);
	import b32wc_pkg::*;

	logic              busy_q;
	logic [WORD_W-1:0] word_q;
	logic [CNT_W-1:0]  cnt_q;
	mode_t             mode_q;

	logic              out_valid_q;
	logic [7:0]        out_data_q;
	logic              out_last_q;

	logic              emit;
	logic              final_emit;

	assign result.valid    = out_valid_q;
	assign result.data_out = out_data_q;
	assign result.last_out = out_last_q;

	assign emit       = busy_q && (!out_valid_q || result.ready);
	assign final_emit = emit && (cnt_q == CNT_W'(1));
	// next job slips in behind the final request of the current one
	assign pop        = q_valid && (!busy_q || final_emit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit)
				out_valid_q <= 1'b1;
			else if (result.ready)
				out_valid_q <= 1'b0;
			if (pop)
				busy_q <= 1'b1;
			else if (final_emit)
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_last_q <= final_emit;
			if (mode_q == MODE_DEC)
				out_data_q <= word_q[7:0];
			else
				out_data_q <= digit_char(word_q[4:0]);
		end
		if (pop) begin
			word_q <= q_head.word;
			cnt_q  <= q_head.cnt;
			mode_q <= q_head.mode;
		end else if (emit) begin
			cnt_q <= cnt_q - 1'b1;
			if (mode_q == MODE_DEC)
				word_q <= word_q >> 8;
			else
				word_q <= word_q >> 5;
		end
	end

	a_busy_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (cnt_q != '0 && cnt_q <= CNT_W'(WORD_DIGITS)))
		else $error("busy with no requests left");
	a_last_mark: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> result.valid && (result.last_out == $past(cnt_q == CNT_W'(1))))
		else $error("last flag out of step with count");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (!busy_q || final_emit))
		else $error("job taken while one still running");
endmodule

@@ rtl/core/base32_word_codec.sv @@
`timescale 1ns / 1ps
// Streaming base32 codec, alphabet '@', 'a'..'z', '3'..'7', over 64-bit words.
// Channels: item (data_in, last_in) carries bytes when encoding and characters
// when decoding; result (data_out, last_out) carries the other side. Both are
// valid/ready; a request moves when valid and ready are high at a clock edge.
// cfg writes the mode bit (0 encode, 1 decode), is always ready, and clears
// any group in progress. Write it only while the codec is idle.
// Encode: 8 bytes give 13 characters; an item with last_in flushes a short
// word as ceil(n*8/5) characters. Decode: 13 characters give 8 bytes; last_in
// flushes floor(n*5/8) bytes, none for a single character.
// A closed group goes as a job into the queue; the output serialiser loads it
// and shifts each result into a single output register. Results leave at one
// per cycle while the receiver is ready: one item per cycle decoding, while
// encoding the input waits on the output, as 8 bytes give 13 characters. A job
// queue of QUEUE_DEPTH entries sits between the accumulator and the output
// serialiser; item.ready drops only while that queue is full.
// Reset clears mode to encode, the accumulator and all valid flags. When the
// receiver stalls, the output register holds and, once the queue fills, the
// input stalls too.
module base32_word_codec #(
	parameter int QUEUE_DEPTH = b32wc_pkg::QUEUE_DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	b32_cfg_if.sink      cfg,
	b32_item_if.sink     item,
	b32_result_if.source result
);
	import b32wc_pkg::*;

	mode_t mode_q;
	logic  cfg_wr;
	logic  q_full;
	logic  q_valid;
	logic  push;
	logic  pop;
	job_t  wr_job;
	job_t  q_head;

	assign cfg.ready = 1'b1;
	assign cfg_wr    = cfg.valid && cfg.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mode_q <= MODE_ENC;
		else if (cfg_wr)
			mode_q <= mode_t'(cfg.data);
	end

	b32wc_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.mode   (mode_q),
		.clr    (cfg_wr),
		.q_full (q_full),
		.push   (push),
		.job    (wr_job)
	);

	b32wc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (wr_job),
		.full   (q_full),
		.valid  (q_valid),
		.pop    (pop),
		.head   (q_head)
	);

	b32wc_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_head  (q_head),
		.pop     (pop),
		.result  (result)
	);
endmodule
